[rtl/core/iup_pkg.sv]
// Shared types and constants for the integer pixel upscaler.
`default_nettype none

package iup_pkg;

    // Field and register widths
    localparam int SCALE_W    = 5;
    localparam int WIDTH_W    = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int ROWS_W     = 4;
    localparam int CHAN_W     = 8;
    localparam int PAD_W      = 2;

    // Default sizing
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int DEFAULT_MAX_SCALE = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

    // Operation codes
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Tag carried by the read stage toward the emitter
    typedef struct packed {
        logic is_push;
        logic row_end;
    } stage_tag_t;

endpackage

`default_nettype wire

[rtl/core/iup_in_if.sv]
// Input channel: operation and pushed pixel with valid/ready.
`default_nettype none

interface iup_in_if;
    import iup_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;

    modport source (output valid, output operation, output blue, output green,
                    output red, input ready);
    modport sink   (input valid, input operation, input blue, input green,
                    input red, output ready);
endinterface

`default_nettype wire

[rtl/core/iup_out_if.sv]
// Output channel: replicated pixel with row marks and valid/ready.
`default_nettype none

interface iup_out_if;
    import iup_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              row_end;
    logic [PAD_W-1:0]  pad_count;
    logic              last;

    modport source (output valid, output out_blue, output out_green, output out_red,
                    output row_end, output pad_count, output last, input ready);
    modport sink   (input valid, input out_blue, input out_green, input out_red,
                    input row_end, input pad_count, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/integer_pixel_upscaler_core.sv]
// Nearest-neighbor integer upscaler core with line buffer and replay emitter.
//
// Each accepted push writes its pixel into the line buffer and produces
// scale output transactions; each accepted replay reads the next buffered
// pixel and produces scale transactions as well. The emitter register that
// drives the output sends one transaction per cycle while the receiver is
// ready; with scale 1 an item passes every cycle unless the output stalls.
// A dropped item (push while replay rows are owed, replay while none are
// owed) is accepted at the input and produces nothing. The line buffer is a
// single-port-write, single-port-read synchronous RAM with a registered
// read, followed by a one-entry read stage, so the next item is taken
// while the current one is still being replicated. Its contents are
// undefined after reset and need no clearing pass. The user must write
// configuration only while the block is idle; the block does not enforce it.
`default_nettype none

module integer_pixel_upscaler_core #(
    parameter int MAX_WIDTH = iup_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_SCALE = iup_pkg::DEFAULT_MAX_SCALE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [iup_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iup_pkg::CFG_DATA_W-1:0] cfg_data,
    iup_in_if.sink                             pix_in,
    iup_out_if.source                          pix_out
);
    import iup_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = $clog2(MAX_SCALE + 1);

    // Configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;

    // Column and row bookkeeping
    logic [COL_W-1:0]  push_col_reg,  push_col_next;
    logic [COL_W-1:0]  replay_col_reg, replay_col_next;
    logic [ROWS_W-1:0] rows_owed_reg, rows_owed_next;

    // Line buffer and read stage
    pixel_t     line_mem [MAX_WIDTH];
    pixel_t     rdata_reg;
    logic       s1_valid_reg, s1_valid_next;
    stage_tag_t s1_tag_reg;
    pixel_t     s1_pix_reg;

    // Emitter
    logic             em_valid_reg, em_valid_next;
    logic [CNT_W-1:0] em_left_reg, em_left_next;
    pixel_t           em_pix_reg;
    logic             em_end_reg;
    logic [PAD_W-1:0] em_pad_reg;

    logic [CNT_W-1:0] eff_n;
    logic [EW_W-1:0]  eff_w;
    logic [PAD_W-1:0] pad_c;
    logic             in_fire, out_fire, is_push, do_push, do_replay;
    logic             row_end_c, em_last, em_load;
    logic [COL_W-1:0] col_c;
    pixel_t           in_pix;

    // Effective scale and width with out-of-range values clamped
    always_comb
    begin
        if (scale_reg == '0)
            eff_n = CNT_W'(1);
        else if (32'(scale_reg) > 32'(MAX_SCALE))
            eff_n = CNT_W'(MAX_SCALE);
        else
            eff_n = CNT_W'(scale_reg);

        if (width_reg == '0)
            eff_w = EW_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = EW_W'(MAX_WIDTH);
        else
            eff_w = EW_W'(width_reg);
    end

    // Output row width mod 4 only needs the two low bits of each factor
    assign pad_c = PAD_W'(PAD_W'(eff_n) * PAD_W'(eff_w));

    // Handshake and item decode
    assign em_last   = (em_left_reg == CNT_W'(1));
    assign out_fire  = pix_out.valid && pix_out.ready;
    assign em_load   = s1_valid_reg && (!em_valid_reg || (out_fire && em_last));
    assign pix_in.ready = !s1_valid_reg || em_load;
    assign in_fire   = pix_in.valid && pix_in.ready;
    assign is_push   = (pix_in.operation == OP_PUSH);
    assign do_push   = in_fire && is_push && (rows_owed_reg == '0);
    assign do_replay = in_fire && !is_push && (rows_owed_reg != '0);
    assign col_c     = is_push ? push_col_reg : replay_col_reg;
    assign row_end_c = (32'(col_c) + 32'd1) >= 32'(eff_w);
    assign in_pix    = '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};

    // Next state of columns and owed rows
    always_comb
    begin
        push_col_next   = push_col_reg;
        replay_col_next = replay_col_reg;
        rows_owed_next  = rows_owed_reg;
        if (do_push)
        begin
            if (row_end_c)
            begin
                push_col_next  = '0;
                rows_owed_next = ROWS_W'(eff_n - CNT_W'(1));
            end
            else
                push_col_next = COL_W'(push_col_reg + COL_W'(1));
        end
        else if (do_replay)
        begin
            if (row_end_c)
            begin
                replay_col_next = '0;
                rows_owed_next  = ROWS_W'(rows_owed_reg - ROWS_W'(1));
            end
            else
                replay_col_next = COL_W'(replay_col_reg + COL_W'(1));
        end
    end

    // Read stage and emitter next state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = do_push || do_replay;
        else if (em_load)
            s1_valid_next = 1'b0;

        em_valid_next = em_valid_reg;
        em_left_next  = em_left_reg;
        if (em_load)
        begin
            em_valid_next = 1'b1;
            em_left_next  = eff_n;
        end
        else if (out_fire)
        begin
            if (em_last)
                em_valid_next = 1'b0;
            else
                em_left_next = CNT_W'(em_left_reg - CNT_W'(1));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SCALE_W'(1);
            width_reg      <= WIDTH_W'(1);
            push_col_reg   <= '0;
            replay_col_reg <= '0;
            rows_owed_reg  <= '0;
            s1_valid_reg   <= 1'b0;
            em_valid_reg   <= 1'b0;
            em_left_reg    <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_SCALE))
                scale_reg <= cfg_data[SCALE_W-1:0];
            if (cfg_we && (cfg_index == CFG_WIDTH))
                width_reg <= cfg_data[WIDTH_W-1:0];
            push_col_reg   <= push_col_next;
            replay_col_reg <= replay_col_next;
            rows_owed_reg  <= rows_owed_next;
            s1_valid_reg   <= s1_valid_next;
            em_valid_reg   <= em_valid_next;
            em_left_reg    <= em_left_next;
        end
    end

    // Line buffer: write on push, registered read on replay
    always_ff @(posedge clk)
    begin
        if (do_push)
            line_mem[push_col_reg] <= in_pix;
        if (do_replay)
            rdata_reg <= line_mem[replay_col_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_tag_reg <= '{is_push: is_push, row_end: row_end_c};
            s1_pix_reg <= in_pix;
        end
        if (em_load)
        begin
            em_pix_reg <= s1_tag_reg.is_push ? s1_pix_reg : rdata_reg;
            em_end_reg <= s1_tag_reg.row_end;
            em_pad_reg <= pad_c;
        end
    end

    // Output drive
    assign pix_out.valid     = em_valid_reg;
    assign pix_out.out_blue  = em_pix_reg.blue;
    assign pix_out.out_green = em_pix_reg.green;
    assign pix_out.out_red   = em_pix_reg.red;
    assign pix_out.row_end   = em_end_reg && em_last;
    assign pix_out.pad_count = (em_end_reg && em_last) ? em_pad_reg : '0;
    assign pix_out.last      = em_last;

    // Checks
    a_em_count: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg |-> (em_left_reg != '0))
        else $error("emitter valid with zero copies left");

    a_push_col_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_owed_reg != '0) |-> (push_col_reg == '0))
        else $error("push column nonzero while replay rows owed");

    a_replay_col_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_owed_reg == '0) |-> (replay_col_reg == '0))
        else $error("replay column nonzero with no rows owed");

    a_em_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && em_last && !s1_valid_reg) |=> !em_valid_reg)
        else $error("emitter stayed valid after its final copy");

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the integer pixel upscaler core: directed and random rows, self-checking.
`timescale 1ns / 1ps

module tb;
    import iup_pkg::*;

    localparam int    DRAIN_CYCLES = 16;
    localparam int    CYCLE_LIMIT  = 1000000;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    BUF_DEPTH    = DEFAULT_MAX_WIDTH;
    localparam int    SCALE_TOP    = DEFAULT_MAX_SCALE;

    // One replicated output pixel as the core should send it
    typedef struct packed {
        pixel_t           px;
        logic             row_end;
        logic [PAD_W-1:0] pad_count;
        logic             last;
    } out_pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    iup_in_if  pix_in ();
    iup_out_if pix_out ();

    integer_pixel_upscaler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    // Upscaler shadow state
    pixel_t          line_buf [BUF_DEPTH];
    int unsigned     push_col   = 0;
    int unsigned     replay_col = 0;
    logic [ROWS_W-1:0] rows_owed = '0;
    logic [SCALE_W-1:0] scale_reg = 5'd1;
    logic [WIDTH_W-1:0] width_reg = 11'd1;

    out_pixel_t  expected_pixels [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned hold_left      = 0;
    logic        hold_go        = 1'b0;

    always #10 clk = ~clk;

    // Work out the pixels one accepted transaction should produce
    function automatic void predict_item(input logic op, input pixel_t px);
        int unsigned n;
        int unsigned w;
        int unsigned col;
        logic [PAD_W-1:0] pad;
        logic ends;
        pixel_t src;
        out_pixel_t res;
        n = (scale_reg == 0) ? 1 : ((scale_reg > SCALE_TOP) ? SCALE_TOP : scale_reg);
        w = (width_reg == 0) ? 1 : ((width_reg > BUF_DEPTH) ? BUF_DEPTH : width_reg);
        pad = PAD_W'((n * w) & 3);
        if (op == OP_PUSH) begin
            // a push is dropped while replay rows are owed
            if (rows_owed != 0)
                return;
            col = (push_col >= BUF_DEPTH) ? BUF_DEPTH - 1 : push_col;
            line_buf[col] = px;
            src = px;
        end
        else begin
            // a replay is dropped when nothing is owed
            if (rows_owed == 0)
                return;
            col = (replay_col >= BUF_DEPTH) ? BUF_DEPTH - 1 : replay_col;
            src = line_buf[col];
        end
        ends = (col + 1 >= w);
        for (int unsigned k = 0; k < n; k++) begin
            res.px        = src;
            res.last      = (k + 1 == n);
            res.row_end   = res.last && ends;
            res.pad_count = res.row_end ? pad : '0;
            expected_pixels.push_back(res);
        end
        if (op == OP_PUSH) begin
            push_col = ends ? 0 : col + 1;
            if (ends)
                rows_owed = ROWS_W'(n - 1);
        end
        else begin
            replay_col = ends ? 0 : col + 1;
            if (ends)
                rows_owed = rows_owed - 1'b1;
        end
    endfunction

    function automatic pixel_t random_pixel();
        logic [3*CHAN_W-1:0] bits;
        bits = (3*CHAN_W)'($urandom);
        return pixel_t'(bits);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Offer one transaction, hold it until accepted, then predict its output
    task automatic send_item(input logic op, input pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid     <= 1'b1;
        pix_in.operation <= op;
        pix_in.blue      <= px.blue;
        pix_in.green     <= px.green;
        pix_in.red       <= px.red;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        predict_item(op, px);
    endtask

    // Let every expected pixel arrive, then allow in-flight dropped items to settle
    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SCALE)
            scale_reg = val[SCALE_W-1:0];
        else
            width_reg = val[WIDTH_W-1:0];
    endtask

    // Reset defaults, extreme pixel values, scale 3 rows and both kinds of dropped item
    task automatic test_basic_rows();
        send_item(OP_PUSH, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        send_item(OP_PUSH, '{red: 8'h00, green: 8'h00, blue: 8'h00});
        send_item(OP_REPLAY, '{red: 8'hFF, green: 8'h00, blue: 8'hFF});
        wait_idle();
        write_reg(CFG_SCALE, 11'd3);
        write_reg(CFG_WIDTH, 11'd2);
        send_item(OP_PUSH, '{red: 8'h7F, green: 8'h80, blue: 8'h01});
        send_item(OP_PUSH, '{red: 8'h80, green: 8'h7F, blue: 8'hFE});
        send_item(OP_PUSH, '{red: 8'hAA, green: 8'h55, blue: 8'hAA});
        repeat (4) send_item(OP_REPLAY, '{red: 8'h00, green: 8'h00, blue: 8'h00});
        send_item(OP_REPLAY, '{red: 8'h55, green: 8'hAA, blue: 8'h55});
    endtask

    // Out-of-range register values, and a row ended by narrowing the width
    task automatic test_clamped_registers();
        wait_idle();
        write_reg(CFG_SCALE, 11'd31);
        write_reg(CFG_WIDTH, 11'd1024);
        send_item(OP_PUSH, '{red: 8'h12, green: 8'h34, blue: 8'h56});
        wait_idle();
        write_reg(CFG_WIDTH, 11'd2047);
        send_item(OP_PUSH, '{red: 8'hC3, green: 8'h3C, blue: 8'h96});
        wait_idle();
        write_reg(CFG_SCALE, 11'd0);
        write_reg(CFG_WIDTH, 11'd0);
        send_item(OP_PUSH, '{red: 8'h01, green: 8'h02, blue: 8'h04});
    endtask

    // Narrowing the width while replay rows are still owed
    task automatic test_narrowed_width();
        wait_idle();
        write_reg(CFG_SCALE, 11'd2);
        write_reg(CFG_WIDTH, 11'd4);
        repeat (4) send_item(OP_PUSH, random_pixel());
        send_item(OP_REPLAY, random_pixel());
        wait_idle();
        write_reg(CFG_WIDTH, 11'd2);
        send_item(OP_REPLAY, random_pixel());
    endtask

    // Receiver holds off for a long stretch while scale 16 replays keep coming
    task automatic test_backpressure_hold();
        wait_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(CFG_SCALE, 11'd16);
        write_reg(CFG_WIDTH, 11'd1);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        send_item(OP_PUSH, random_pixel());
        while (rows_owed != 0)
            send_item(OP_REPLAY, random_pixel());
    endtask

    // Whole source rows with random content and sizes, salted with dropped items
    task automatic test_random_rows(input int unsigned idle_pct, input int unsigned stl_pct,
                                    input int unsigned budget);
        int unsigned done;
        int unsigned w;
        logic [CFG_DATA_W-1:0] s;
        done = 0;
        while (done < budget) begin
            wait_idle();
            send_idle_pct = idle_pct;
            stall_pct     = stl_pct;
            if ($urandom_range(99) < 15) begin
                s = CFG_DATA_W'($urandom_range(31, 0));
                w = $urandom_range(2, 1);
            end
            else begin
                s = CFG_DATA_W'($urandom_range(4, 1));
                w = $urandom_range(8, 1);
            end
            write_reg(CFG_SCALE, s);
            write_reg(CFG_WIDTH, CFG_DATA_W'(w));
            repeat ($urandom_range(3, 1)) begin
                for (int unsigned c = 0; c < w; c++) begin
                    if ($urandom_range(9) == 0)
                        send_item(OP_REPLAY, random_pixel());
                    send_item(OP_PUSH, random_pixel());
                    done++;
                end
                while (rows_owed != 0) begin
                    if ($urandom_range(9) == 0)
                        send_item(OP_PUSH, random_pixel());
                    send_item(OP_REPLAY, random_pixel());
                    done++;
                end
            end
        end
    endtask

    // Output checker
    always @(posedge clk) begin : check_output
        out_pixel_t want;
        if (rst_n && pix_out.valid && pix_out.ready) begin
            if (expected_pixels.size() == 0)
                report_mismatch("output transaction with nothing expected");
            else begin
                want = expected_pixels.pop_front();
                if (pix_out.out_blue !== want.px.blue)
                    report_mismatch($sformatf("out_blue got %0h want %0h",
                                              pix_out.out_blue, want.px.blue));
                if (pix_out.out_green !== want.px.green)
                    report_mismatch($sformatf("out_green got %0h want %0h",
                                              pix_out.out_green, want.px.green));
                if (pix_out.out_red !== want.px.red)
                    report_mismatch($sformatf("out_red got %0h want %0h",
                                              pix_out.out_red, want.px.red));
                if (pix_out.row_end !== want.row_end)
                    report_mismatch($sformatf("row_end got %0b want %0b",
                                              pix_out.row_end, want.row_end));
                if (pix_out.pad_count !== want.pad_count)
                    report_mismatch($sformatf("pad_count got %0d want %0d",
                                              pix_out.pad_count, want.pad_count));
                if (pix_out.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              pix_out.last, want.last));
            end
        end
    end

    // Long receiver hold-off, counted down here
    always @(posedge clk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: random stalls, forced low during a hold-off
    always @(posedge clk)
        pix_out.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        pix_in.valid     <= 1'b0;
        pix_in.operation <= OP_PUSH;
        pix_in.blue      <= '0;
        pix_in.green     <= '0;
        pix_in.red       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_rows();
        test_clamped_registers();
        test_narrowed_width();
        test_backpressure_hold();
        test_random_rows(0, 0, 45);
        test_random_rows(68, 0, 45);
        test_random_rows(0, 68, 45);
        test_random_rows(19, 19, 45);
        wait_idle();

        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
